// ----- design/adq_pkg.sv -----
// ----------------------------------------------------------------------------
// adq_pkg
// Shared types and constants of the array double-ended queue unit.
// ----------------------------------------------------------------------------
package adq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int CAP_W         = 5;
   localparam int PADDR_W       = 3;
   localparam int PDATA_W       = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // register index as seen on paddr[2]
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      CMD_INSERT_REAR  = 2'd0,
      CMD_DELETE_FRONT = 2'd1,
      CMD_INSERT_FRONT = 2'd2,
      CMD_DELETE_REAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL_REAR = 2'd1,
      STATUS_NO_FRONT  = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_READ = 1'b1
   } fsm_state_type;

   typedef struct packed {
      logic [1:0]               command;
      logic signed [DATA_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] removed_value;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic finish_read;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic need_read;
   } dp_status_type;

endpackage

// ----- design/adq_ram.sv -----
// ----------------------------------------------------------------------------
// adq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module adq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/adq_ctrl.sv -----
// ----------------------------------------------------------------------------
// adq_ctrl
// Command sequencer: takes a beat, then on deletes waits for the registered RAM read data.
// ----------------------------------------------------------------------------
module adq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  adq_pkg::dp_status_type dp_status,
   output logic                  req_stall,
   output adq_pkg::ctrl_cmd_type ctrl_cmd
);

   adq_pkg::fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adq_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in             = state_ff;
      req_stall            = 1'b1;
      ctrl_cmd.accept      = 1'b0;
      ctrl_cmd.finish_read = 1'b0;
      unique case (state_ff)
         adq_pkg::FSM_IDLE: begin
            req_stall       = !dp_status.out_free;
            ctrl_cmd.accept = req_valid && dp_status.out_free;
            if (ctrl_cmd.accept && dp_status.need_read) begin
               state_in = adq_pkg::FSM_READ;
            end
         end
         adq_pkg::FSM_READ: begin
            // ram data is valid now, move it out once the output slot frees
            if (dp_status.out_free) begin
               ctrl_cmd.finish_read = 1'b1;
               state_in             = adq_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = adq_pkg::FSM_IDLE;
         end
      endcase
   end

endmodule

// ----- design/adq_datapath.sv -----
// ----------------------------------------------------------------------------
// adq_datapath
// Pointers, capacity register, entry store and result register.
// ----------------------------------------------------------------------------
module adq_datapath #(
   parameter int DEPTH = adq_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  adq_pkg::req_payload_type        req_payload,
   output adq_pkg::rsp_payload_type        rsp_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [adq_pkg::PADDR_W-1:0]     csr_paddr,
   input  logic [adq_pkg::PDATA_W-1:0]     csr_pwdata,
   output logic [adq_pkg::PDATA_W-1:0]     csr_prdata,
   input  adq_pkg::ctrl_cmd_type           ctrl_cmd,
   output adq_pkg::dp_status_type          dp_status
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PTR_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (PTR_W > adq_pkg::CAP_W) ? PTR_W : adq_pkg::CAP_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   logic [PTR_W-1:0]          front_ff, front_in;
   logic [PTR_W-1:0]          rear_ff, rear_in;
   logic [adq_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   adq_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic                      empty;
   logic                      full_rear;
   logic [PTR_W-1:0]          front_dec;
   logic [PTR_W-1:0]          rear_dec;
   logic                      wr_want;
   logic                      rd_want;
   logic [ADDR_W-1:0]         wr_addr;
   logic [ADDR_W-1:0]         rd_addr;
   logic [adq_pkg::DATA_W-1:0] rd_data;
   logic [PTR_W-1:0]          front_next;
   logic [PTR_W-1:0]          rear_next;
   adq_pkg::status_type       status_now;
   logic                      csr_write;

   // csr
   assign csr_write = csr_psel && csr_penable && csr_pwrite
                      && (csr_paddr[2] == adq_pkg::REG_CAPACITY);
   assign cap_in    = csr_write ? csr_pwdata[adq_pkg::CAP_W-1:0] : cap_ff;
   assign csr_prdata = (csr_paddr[2] == adq_pkg::REG_CAPACITY)
                       ? adq_pkg::PDATA_W'(cap_ff) : '0;

   // command decode
   assign empty     = front_ff >= rear_ff;
   assign full_rear = (CMP_W'(rear_ff) >= CMP_W'(cap_ff)) || (CMP_W'(rear_ff) >= DEPTH_C);
   assign front_dec = front_ff - PTR_W'(1);
   assign rear_dec  = rear_ff - PTR_W'(1);

   always_comb begin
      status_now = adq_pkg::STATUS_DONE;
      front_next = front_ff;
      rear_next  = rear_ff;
      wr_want    = 1'b0;
      rd_want    = 1'b0;
      wr_addr    = rear_ff[ADDR_W-1:0];
      rd_addr    = front_ff[ADDR_W-1:0];
      unique case (adq_pkg::cmd_type'(req_payload.command))
         adq_pkg::CMD_INSERT_REAR: begin
            if (full_rear) begin
               status_now = adq_pkg::STATUS_FULL_REAR;
            end else begin
               wr_want   = 1'b1;
               rear_next = rear_ff + PTR_W'(1);
            end
         end
         adq_pkg::CMD_INSERT_FRONT: begin
            if (front_ff == '0) begin
               status_now = adq_pkg::STATUS_NO_FRONT;
            end else begin
               wr_want    = 1'b1;
               wr_addr    = front_dec[ADDR_W-1:0];
               front_next = front_dec;
            end
         end
         adq_pkg::CMD_DELETE_FRONT: begin
            if (empty) begin
               status_now = adq_pkg::STATUS_EMPTY;
               front_next = '0;
               rear_next  = '0;
            end else begin
               rd_want    = 1'b1;
               front_next = front_ff + PTR_W'(1);
            end
         end
         adq_pkg::CMD_DELETE_REAR: begin
            if (empty) begin
               status_now = adq_pkg::STATUS_EMPTY;
               front_next = '0;
               rear_next  = '0;
            end else begin
               rd_want   = 1'b1;
               rd_addr   = rear_dec[ADDR_W-1:0];
               rear_next = rear_dec;
            end
         end
         default: begin
            status_now = adq_pkg::STATUS_DONE;
         end
      endcase
   end

   assign front_in = ctrl_cmd.accept ? front_next : front_ff;
   assign rear_in  = ctrl_cmd.accept ? rear_next : rear_ff;

   adq_ram #(
      .WIDTH (adq_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_adq_ram (
      .clock   (clock),
      .wr_en   (ctrl_cmd.accept && wr_want),
      .wr_addr (wr_addr),
      .wr_data (req_payload.value),
      .rd_en   (ctrl_cmd.accept && rd_want),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      priority if (ctrl_cmd.accept && !rd_want) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.status        = status_now;
         rsp_payload_in.removed_value = '0;
      end else if (ctrl_cmd.finish_read) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.status        = adq_pkg::STATUS_DONE;
         rsp_payload_in.removed_value = rd_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         rear_ff      <= '0;
         cap_ff       <= adq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload         = rsp_payload_ff;
   assign dp_status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign dp_status.need_read = rd_want;

endmodule

// ----- design/array_double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// array_double_ended_queue_unit
// Linear-array deque: insert or delete at either end, one result per command.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  command, value
//   rsp_     out        rsp_valid/rsp_stall  status, removed_value
//   csr_     in/out     apb psel/penable     capacity at byte address 0
//
// inserts and failed commands are written straight into the result register; a delete
//   from a non-empty queue first passes the registered read port of the entry ram
// a new beat is taken while the sequencer is idle and the result register is empty or drains that cycle
// reset clears the pointers and sets capacity to 16; the entry store is not
//   cleared, no clearing pass
// a stalled result holds in the output register and blocks further beats
//
module array_double_ended_queue_unit #(
   parameter int DEPTH = adq_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // command beats
   input  logic                        req_valid,
   output logic                        req_stall,
   input  adq_pkg::req_payload_type    req_payload,
   // result beats
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output adq_pkg::rsp_payload_type    rsp_payload,
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [adq_pkg::PADDR_W-1:0] csr_paddr,
   input  logic [adq_pkg::PDATA_W-1:0] csr_pwdata,
   output logic [adq_pkg::PDATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);

   adq_pkg::ctrl_cmd_type  ctrl_cmd;
   adq_pkg::dp_status_type dp_status;

   // no wait states on the register port
   assign csr_pready = 1'b1;

   // sequencer: idle or waiting on ram data
   adq_ctrl u_adq_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .dp_status (dp_status),
      .req_stall (req_stall),
      .ctrl_cmd  (ctrl_cmd)
   );

   // pointers, store and result register
   adq_datapath #(
      .DEPTH (DEPTH)
   ) u_adq_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .ctrl_cmd    (ctrl_cmd),
      .dp_status   (dp_status)
   );

endmodule

// ----- design/adq_checker.sv -----
// ----------------------------------------------------------------------------
// adq_checker
// Port-level checks of the deque unit, bound to the top level.
// ----------------------------------------------------------------------------
module adq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input adq_pkg::req_payload_type    req_payload,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input adq_pkg::rsp_payload_type    rsp_payload,
   input logic                        csr_psel,
   input logic                        csr_penable,
   input logic                        csr_pwrite,
   input logic [adq_pkg::PADDR_W-1:0] csr_paddr,
   input logic [adq_pkg::PDATA_W-1:0] csr_pwdata,
   input logic [adq_pkg::PDATA_W-1:0] csr_prdata
);

   // nothing pending right after reset
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result beat holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   // failed commands never carry data
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != adq_pkg::STATUS_DONE)
      |-> (rsp_payload.removed_value == '0))
      else $error("failed command returned data");

   // an insert answers in the next cycle and never reports empty
   a_insert_next : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall
      && ((req_payload.command == adq_pkg::CMD_INSERT_REAR)
          || (req_payload.command == adq_pkg::CMD_INSERT_FRONT))
      |=> rsp_valid && (rsp_payload.status != adq_pkg::STATUS_EMPTY))
      else $error("insert result late or wrong status");

   // capacity readback follows the last write
   a_cap_readback : assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite
       && (csr_paddr[2] == adq_pkg::REG_CAPACITY))
      ##1 (csr_paddr[2] == adq_pkg::REG_CAPACITY)
      |-> (csr_prdata[adq_pkg::CAP_W-1:0] == $past(csr_pwdata[adq_pkg::CAP_W-1:0])))
      else $error("capacity readback mismatch");

endmodule

bind array_double_ended_queue_unit adq_checker u_adq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);
